// ===== hdl/qap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_pkg: shared types and constants of the quantized average pool
// Request and response payloads, command and register codes, fixed widths.
// ----------------------------------------------------------------------------
package qap_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W  = 7;   // col and row of a request
  localparam int unsigned PIXEL_W  = 8;   // pixel and average width
  localparam int unsigned SMALL_W  = 5;   // stride and window registers
  localparam int unsigned ORIGIN_W = COORD_W + SMALL_W;  // col * stride
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Request commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_H    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_V    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH  = 3'd7;

  // Request payload
  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [PIXEL_W-1:0] average_value;
    logic               empty_window;
  } rsp_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage : qap_pkg
`default_nettype wire

// ===== hdl/qap_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_req_if: request channel
// Valid/ready channel that carries load and compute requests.
// ----------------------------------------------------------------------------
interface qap_req_if;
  logic         valid;
  logic         ready;
  qap_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface : qap_req_if
`default_nettype wire

// ===== hdl/qap_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_rsp_if: response channel
// Valid/ready channel that carries one pooled result per compute request.
// ----------------------------------------------------------------------------
interface qap_rsp_if;
  logic         valid;
  logic         ready;
  qap_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface : qap_rsp_if
`default_nettype wire

// ===== hdl/qap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : qap_ram
`default_nettype wire

// ===== hdl/qap_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_div: serial restoring divider
// Produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qap_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [NUM_W-1:0]     numer_i,
  input  wire logic [DEN_W-1:0]     denom_i,
  output      logic [NUM_W-1:0]     quotient_o,
  output      qap_pkg::div_status_t status_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = (trial >= {1'b0, den_q});
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = numer_i;
      den_d  = denom_i;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule : qap_div
`default_nettype wire

// ===== hdl/quantized_average_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_average_pool: 8-bit average pooling over one stored image plane
//
// Requests arrive on req_i. A load request writes one pixel into the image
// RAM if its coordinates lie inside it. A compute request names an output
// column and row; the block reads the clipped window from the RAM one pixel
// per cycle, divides the rounded sum by the pixel count in a serial divider
// and places one result on rsp_o; an empty window skips the read and the
// divide. Loads produce no response. A compute request occupies the block
// while it reads the nx*ny pixels of the clipped window (at most MAX_WINDOW
// squared) and while the NUM_W-bit divider (18 bits at the default sizes)
// runs; the single RAM read port and the one-bit-per-cycle divider bound
// its speed. Requests are handled one at a time; loads go one per cycle
// while the block is idle.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls with a result still pending, a finished
// compute waits until that register frees up.
// Reset restores the config defaults, clears the response register and idles
// the sequencer. The image RAM is not cleared; unloaded pixels are undefined.
// The user must write configuration on the cfg port while idle; not enforced.
// ----------------------------------------------------------------------------
module quantized_average_pool #(
  parameter int unsigned MAX_IMAGE_WIDTH  = 128,
  parameter int unsigned MAX_IMAGE_HEIGHT = 128,
  parameter int unsigned MAX_WINDOW       = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [qap_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [qap_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  qap_req_if.sink                               req_i,
  qap_rsp_if.source                             rsp_o
);

  localparam int unsigned DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned SPAN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = CNT_W + qap_pkg::PIXEL_W;
  localparam int unsigned NUM_W  = SUM_W + 1;
  localparam int unsigned END_W  = qap_pkg::ORIGIN_W + 1;
  localparam int unsigned PW     = qap_pkg::PIXEL_W;
  localparam int unsigned SW     = qap_pkg::SMALL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_READ,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_RESULT
  } state_e;

  // Configuration registers
  logic [SW-1:0] stride_h_q, stride_v_q, window_w_q, window_h_q;
  logic [PW-1:0] image_w_q, image_h_q, clamp_low_q, clamp_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_h_q   <= SW'(1);
      stride_v_q   <= SW'(1);
      window_w_q   <= SW'(1);
      window_h_q   <= SW'(1);
      image_w_q    <= PW'(128);
      image_h_q    <= PW'(128);
      clamp_low_q  <= '0;
      clamp_high_q <= PW'(255);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qap_pkg::CFG_STRIDE_H:   stride_h_q   <= SW'(cfg_wdata_i);
        qap_pkg::CFG_STRIDE_V:   stride_v_q   <= SW'(cfg_wdata_i);
        qap_pkg::CFG_WINDOW_W:   window_w_q   <= SW'(cfg_wdata_i);
        qap_pkg::CFG_WINDOW_H:   window_h_q   <= SW'(cfg_wdata_i);
        qap_pkg::CFG_IMAGE_W:    image_w_q    <= cfg_wdata_i;
        qap_pkg::CFG_IMAGE_H:    image_h_q    <= cfg_wdata_i;
        qap_pkg::CFG_CLAMP_LOW:  clamp_low_q  <= cfg_wdata_i;
        qap_pkg::CFG_CLAMP_HIGH: clamp_high_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  state_e                        state_q;
  logic [SPAN_W-1:0]             xi_q, yi_q;
  logic                          rd_pend_q;
  logic                          rsp_valid_q;
  qap_pkg::rsp_t                 rsp_q;

  logic [qap_pkg::ORIGIN_W-1:0]  x0_q, y0_q;
  logic [SPAN_W-1:0]             nx_q, ny_q;
  logic [AW-1:0]                 row_base_q;
  logic [CNT_W-1:0]              count_q;
  logic [SUM_W-1:0]              sum_q;
  logic                          empty_q;

  logic                          req_fire;
  logic                          load_in_range;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [PW-1:0]                 ram_rdata;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Load path: write one pixel when its coordinates lie inside the RAM
  always_comb begin
    load_in_range = (32'(req_i.payload.col) < 32'(MAX_IMAGE_WIDTH)) &&
                    (32'(req_i.payload.row) < 32'(MAX_IMAGE_HEIGHT));
    ram_we    = req_fire && (req_i.payload.command == qap_pkg::CMD_LOAD) && load_in_range;
    ram_waddr = AW'(32'(req_i.payload.row) * 32'(MAX_IMAGE_WIDTH) +
                    32'(req_i.payload.col));
  end

  // Window clipping against the saturated image and window sizes
  logic [SW-1:0]     ww_sat, wh_sat;
  logic [END_W-1:0]  iw_sat, ih_sat, x_end, y_end, x_clip, y_clip;
  logic [SPAN_W-1:0] nx_d, ny_d;

  always_comb begin
    ww_sat = (32'(window_w_q) > 32'(MAX_WINDOW)) ? SW'(MAX_WINDOW) : window_w_q;
    wh_sat = (32'(window_h_q) > 32'(MAX_WINDOW)) ? SW'(MAX_WINDOW) : window_h_q;
    iw_sat = (32'(image_w_q) > 32'(MAX_IMAGE_WIDTH)) ?
             END_W'(MAX_IMAGE_WIDTH) : END_W'(image_w_q);
    ih_sat = (32'(image_h_q) > 32'(MAX_IMAGE_HEIGHT)) ?
             END_W'(MAX_IMAGE_HEIGHT) : END_W'(image_h_q);
    x_end  = END_W'(x0_q) + END_W'(ww_sat);
    y_end  = END_W'(y0_q) + END_W'(wh_sat);
    x_clip = (x_end > iw_sat) ? iw_sat : x_end;
    y_clip = (y_end > ih_sat) ? ih_sat : y_end;
    nx_d   = (x_clip > END_W'(x0_q)) ? SPAN_W'(x_clip - END_W'(x0_q)) : '0;
    ny_d   = (y_clip > END_W'(y0_q)) ? SPAN_W'(y_clip - END_W'(y0_q)) : '0;
  end

  // Window read address
  logic last_col, last_row;

  always_comb begin
    last_col  = (xi_q == SPAN_W'(nx_q - SPAN_W'(1)));
    last_row  = (yi_q == SPAN_W'(ny_q - SPAN_W'(1)));
    ram_re    = (state_q == S_READ);
    ram_raddr = row_base_q + AW'(x0_q) + AW'(xi_q);
  end

  qap_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.payload.pixel),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Serial divider for the rounded average
  logic                 div_start;
  logic [NUM_W-1:0]     div_numer;
  logic [NUM_W-1:0]     div_quot;
  qap_pkg::div_status_t div_status;

  assign div_start = (state_q == S_DIV_START);
  assign div_numer = NUM_W'(sum_q) + NUM_W'(count_q >> 1);

  qap_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .numer_i    (div_numer),
    .denom_i    (count_q),
    .quotient_o (div_quot),
    .status_o   (div_status)
  );

  // Saturate and clamp the average
  logic [PW-1:0] avg_pre, avg_lo, avg_out;
  logic          rsp_free;

  always_comb begin
    if (empty_q) begin
      avg_pre = '0;
    end else if (div_quot > NUM_W'(255)) begin
      avg_pre = PW'(255);
    end else begin
      avg_pre = PW'(div_quot);
    end
    avg_lo   = (avg_pre < clamp_low_q) ? clamp_low_q : avg_pre;
    avg_out  = (avg_lo > clamp_high_q) ? clamp_high_q : avg_lo;
    rsp_free = !rsp_valid_q || rsp_o.ready;
  end

  // Datapath registers of the current compute request
  always_ff @(posedge clk_i) begin
    if (req_fire && (req_i.payload.command == qap_pkg::CMD_COMPUTE)) begin
      x0_q <= qap_pkg::ORIGIN_W'(req_i.payload.col) * qap_pkg::ORIGIN_W'(stride_h_q);
      y0_q <= qap_pkg::ORIGIN_W'(req_i.payload.row) * qap_pkg::ORIGIN_W'(stride_v_q);
    end
    if (state_q == S_SPAN) begin
      nx_q       <= nx_d;
      ny_q       <= ny_d;
      empty_q    <= (nx_d == '0) || (ny_d == '0);
      row_base_q <= AW'(32'(y0_q) * 32'(MAX_IMAGE_WIDTH));
      sum_q      <= '0;
    end else begin
      if (rd_pend_q) begin
        sum_q <= sum_q + SUM_W'(ram_rdata);
      end
      if ((state_q == S_READ) && last_col) begin
        row_base_q <= row_base_q + AW'(MAX_IMAGE_WIDTH);
      end
    end
    if (state_q == S_READ) begin
      count_q <= CNT_W'(nx_q) * CNT_W'(ny_q);
    end
  end

  // Sequencer, window counters and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      xi_q        <= '0;
      yi_q        <= '0;
      rd_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rd_pend_q <= (state_q == S_READ);
      // A finished result refills the response register, otherwise it empties
      // once the receiver takes the response.
      if ((state_q == S_RESULT) && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire && (req_i.payload.command == qap_pkg::CMD_COMPUTE)) begin
            state_q <= S_SPAN;
          end
        end
        S_SPAN: begin
          xi_q <= '0;
          yi_q <= '0;
          if ((nx_d == '0) || (ny_d == '0)) begin
            state_q <= S_RESULT;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (last_col) begin
            xi_q <= '0;
            if (last_row) begin
              state_q <= S_DRAIN;
            end else begin
              yi_q <= yi_q + SPAN_W'(1);
            end
          end else begin
            xi_q <= xi_q + SPAN_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DIV_START;
        end
        S_DIV_START: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_status.done) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (rsp_free) begin
            rsp_q.average_value <= avg_out;
            rsp_q.empty_window  <= empty_q;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // The divider is only started when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // Read data arrives in the cycle after a window read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == S_READ))
    else $error("read data pending without a preceding read");

  // Window counters stay inside the clipped span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ((xi_q < nx_q) && (yi_q < ny_q)))
    else $error("window counter outside the clipped span");

  // A division never runs with a zero pixel count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_START) |-> (count_q != '0))
    else $error("division started with zero count");

  // A result is only loaded into a free response register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESULT) && rsp_valid_q && !rsp_o.ready) |=> (state_q == S_RESULT))
    else $error("result left while response register was occupied");

endmodule : quantized_average_pool
`default_nettype wire
